// ===== hw/rtl/fofe_pkg.sv =====
package fofe_pkg;

    localparam int unsigned FOFE_DEPTH = 16;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned KEY_W  = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;

    // command codes; five to seven are no-ops
    localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SERVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SIZE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch item, clear index
        logic rd_head;     // read slot of logical 0
        logic scan_rd;     // key scan read, one per cycle
        logic shift_init;  // index <= best + 1
        logic shift_act;   // gap closing phase
        logic finish;      // commit and load result
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic scan_last;
        logic shift_more;
    } t_dp_sts;

endpackage

// ===== hw/rtl/fofe_ctrl.sv =====
module fofe_ctrl
    import fofe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_sts          i_sts,
    output t_dp_ctl          o_ctl,
    output logic             o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_SCAN_END,
        S_SHIFT_SET,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.capture = 1'b1;
                    if (i_cmd == CMD_SERVE && !i_sts.empty) begin
                        n_state = S_SCAN;
                    end else if ((i_cmd == CMD_DEQ || i_cmd == CMD_PEEK) && !i_sts.empty) begin
                        n_state = S_HEAD;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_HEAD: begin
                o_ctl.rd_head = 1'b1;
                n_state       = S_RESP;
            end
            S_SCAN: begin
                o_ctl.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // last compare lands here
                n_state = S_SHIFT_SET;
            end
            S_SHIFT_SET: begin
                o_ctl.shift_init = 1'b1;
                n_state          = S_SHIFT;
            end
            S_SHIFT: begin
                o_ctl.shift_act = 1'b1;
                if (!i_sts.shift_more) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== hw/rtl/fofe_dp.sv =====
module fofe_dp
    import fofe_pkg::*;
#(
    parameter int unsigned DEPTH = FOFE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctl           i_ctl,
    output t_dp_sts           o_sts,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ID_W-1:0]   i_item_id,
    input  logic [KEY_W-1:0]  i_item_key,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_out_id,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int unsigned IW = $clog2(DEPTH);      // slot index
    localparam int unsigned CW = $clog2(DEPTH + 1);  // count / logical index
    localparam int unsigned SW = CW + 1;             // head + logical sum

    // entry store
    logic [ID_W-1:0]  mem_id  [DEPTH];
    logic [KEY_W-1:0] mem_key [DEPTH];

    logic [IW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_ridx;
    logic              r_cmp_v;
    logic              r_shift_v;
    logic [CMD_W-1:0]  r_cmd;
    logic [ID_W-1:0]   r_in_id;
    logic [KEY_W-1:0]  r_in_key;
    logic [ID_W-1:0]   r_rd_id;
    logic [KEY_W-1:0]  r_rd_key;
    logic [CW-1:0]     r_best;
    logic [ID_W-1:0]   r_best_id;
    logic [KEY_W-1:0]  r_best_key;
    logic              r_valid;
    logic [STAT_W-1:0] r_status;
    logic [ID_W-1:0]   r_out_id;
    logic [KEY_W-1:0]  r_out_key;
    logic [OCC_W-1:0]  r_occ;

    logic              empty, full;
    logic              shift_rd, rd_en, wr_en;
    logic [IW-1:0]     rd_addr, wr_addr;
    logic [ID_W-1:0]   wr_id;
    logic [KEY_W-1:0]  wr_key;
    logic [CW-1:0]     n_count;
    logic [IW-1:0]     n_head;
    logic [STAT_W-1:0] n_status;
    logic [ID_W-1:0]   n_out_id;
    logic [KEY_W-1:0]  n_out_key;
    logic              enq_wr;

    // physical slot of a logical position behind the head
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] lg);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(lg);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign empty = (r_count == '0);
    assign full  = (r_count == CW'(DEPTH));

    assign o_sts.empty      = empty;
    assign o_sts.scan_last  = ((SW'(r_idx) + SW'(1)) == SW'(r_count));
    assign o_sts.shift_more = (r_idx < r_count);

    assign shift_rd = i_ctl.shift_act && (r_idx < r_count);
    assign rd_en    = i_ctl.rd_head || i_ctl.scan_rd || shift_rd;
    assign rd_addr  = slot_of(r_head, r_idx);

    // commit of the finished command
    always_comb begin
        n_count   = r_count;
        n_head    = r_head;
        n_status  = ST_OK;
        n_out_id  = '0;
        n_out_key = '0;
        enq_wr    = 1'b0;
        case (r_cmd)
            CMD_ENQ: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    enq_wr  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DEQ: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_id  = r_rd_id;
                    n_out_key = r_rd_key;
                    n_count   = r_count - CW'(1);
                    n_head    = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
                end
            end
            CMD_SERVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_id  = r_best_id;
                    n_out_key = r_best_key;
                    n_count   = r_count - CW'(1);
                end
            end
            CMD_PEEK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_id  = r_rd_id;
                    n_out_key = r_rd_key;
                end
            end
            CMD_SIZE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    // single write port: gap closing or enqueue
    always_comb begin
        wr_en  = r_shift_v || (i_ctl.finish && enq_wr);
        wr_id  = r_shift_v ? r_rd_id  : r_in_id;
        wr_key = r_shift_v ? r_rd_key : r_in_key;
        if (r_shift_v) begin
            wr_addr = slot_of(r_head, r_ridx - CW'(1));
        end else begin
            wr_addr = slot_of(r_head, r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_id[wr_addr]  <= wr_id;
            mem_key[wr_addr] <= wr_key;
        end
        if (rd_en) begin
            r_rd_id  <= mem_id[rd_addr];
            r_rd_key <= mem_key[rd_addr];
            r_ridx   <= r_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd    <= i_cmd;
            r_in_id  <= i_item_id;
            r_in_key <= i_item_key;
        end
        if (i_ctl.capture) begin
            r_idx <= '0;
        end else if (i_ctl.shift_init) begin
            r_idx <= r_best + CW'(1);
        end else if (i_ctl.scan_rd || shift_rd) begin
            r_idx <= r_idx + CW'(1);
        end
        // first entry seeds the maximum; strict > keeps the earliest on ties
        if (r_cmp_v && (r_ridx == '0 || r_rd_key > r_best_key)) begin
            r_best     <= r_ridx;
            r_best_id  <= r_rd_id;
            r_best_key <= r_rd_key;
        end
        if (i_ctl.finish) begin
            r_status  <= n_status;
            r_out_id  <= n_out_id;
            r_out_key <= n_out_key;
            r_occ     <= OCC_W'(n_count);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_cmp_v   <= 1'b0;
            r_shift_v <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_cmp_v   <= i_ctl.scan_rd;
            r_shift_v <= shift_rd;
            r_valid   <= i_ctl.finish;
            if (i_ctl.finish) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_key   = r_out_key;
    assign o_occupancy = r_occ;

endmodule

// ===== hw/rtl/fifo_with_oldest_first_extract.sv =====
// Bounded queue of DEPTH entries (identifier + 8-bit key) with oldest-first
// extract.
// Command channel: an item is taken on a rising edge with start high and
// busy low. i_cmd selects enqueue, dequeue head, priority serve (first entry
// holding the largest key), peek head or report size.
// Result channel: o_valid is high for exactly one cycle with o_status,
// o_out_id, o_out_key and o_occupancy. The receiver cannot stall; the
// result must be taken in that cycle.
// Sequence after the accept edge: enqueue, size, empty cases and unused
// codes go straight to the result state; dequeue and peek first read the
// head slot; priority serve on n entries, winner at logical position b,
// scans all n keys, then closes the gap behind the winner, then shows
// the result.
// The serve cost is set by the single read port of the entry store: one
// pass reads every key, a second pass moves each entry behind the winner
// one place forward, read and write overlapped.
// busy drops in the cycle o_valid is shown, so a new item may be started
// then. One item is in flight at a time.
// Reset (synchronous, active low) empties the queue and clears o_valid; the
// store itself is not cleared, no entry is read before it is written.
module fifo_with_oldest_first_extract
    import fofe_pkg::*;
#(
    parameter int unsigned DEPTH = FOFE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ID_W-1:0]   i_item_id,
    input  logic [KEY_W-1:0]  i_item_key,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_out_id,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [OCC_W-1:0]  o_occupancy
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    // sequencer: picks the pass sequence per command
    fofe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // store, head/count, key scan and result registers
    fofe_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cmd       (i_cmd),
        .i_item_id   (i_item_id),
        .i_item_key  (i_item_key),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_out_key   (o_out_key),
        .o_occupancy (o_occupancy)
    );

endmodule

// ===== hw/rtl/fofe_chk.sv =====
module fofe_chk
    import fofe_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [STAT_W-1:0] o_status,
    input logic [ID_W-1:0]   o_out_id,
    input logic [KEY_W-1:0]  o_out_key,
    input logic [OCC_W-1:0]  o_occupancy
);

    // busy is high in the cycle after an item is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    // result appears as the block frees up
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_out_id == '0 && o_out_key == '0))
        else $error("payload not zero on error status");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_occupancy == '0))
        else $error("nonzero occupancy with empty status");

endmodule

bind fifo_with_oldest_first_extract fofe_chk u_fofe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_out_id    (o_out_id),
    .o_out_key   (o_out_key),
    .o_occupancy (o_occupancy)
);
